/* design/tmbe_pkg.sv */
`default_nettype none

package tmbe_pkg;

    localparam int ACTION_W  = 4;
    localparam int OPERAND_W = 16;
    localparam int BYTE_W    = 8;
    localparam int PC_OUT_W  = 16;

    typedef enum logic [ACTION_W-1:0] {
        OP_NOP       = 4'd0,
        OP_LEFT_ONE  = 4'd1,
        OP_RIGHT_ONE = 4'd2,
        OP_LEFT_N    = 4'd3,
        OP_RIGHT_N   = 4'd4,
        OP_INC       = 4'd5,
        OP_DEC       = 4'd6,
        OP_ADD       = 4'd7,
        OP_SUB       = 4'd8,
        OP_ZERO      = 4'd9,
        OP_PRINT     = 4'd10,
        OP_INPUT     = 4'd11,
        OP_JZ        = 4'd12,
        OP_JNZ       = 4'd13,
        OP_STOP      = 4'd14
    } t_op;

    // load enables of the two register stages inside the operand reducer
    typedef struct packed {
        logic a;
        logic b;
    } t_pipe_en;

endpackage

`default_nettype wire

/* design/tmbe_in_if.sv */
`default_nettype none

interface tmbe_in_if import tmbe_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [OPERAND_W-1:0] operand;
    logic [BYTE_W-1:0]    input_byte;

    modport source (output valid, output action, output operand, output input_byte,
                    input ready);
    modport sink   (input valid, input action, input operand, input input_byte,
                    output ready);
endinterface

`default_nettype wire

/* design/tmbe_out_if.sv */
`default_nettype none

interface tmbe_out_if import tmbe_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PC_OUT_W-1:0] next_pc;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic                input_taken;
    logic                halted;

    modport source (output valid, output next_pc, output out_valid, output out_byte,
                    output input_taken, output halted, input ready);
    modport sink   (input valid, input next_pc, input out_valid, input out_byte,
                    input input_taken, input halted, output ready);
endinterface

`default_nettype wire

/* design/tmbe_mod_reduce.sv */
`default_nettype none

// 16-bit value modulo a constant, two register stages:
// stage a estimates the quotient with a truncated reciprocal,
// stage b subtracts quotient times divisor and corrects once.
module tmbe_mod_reduce import tmbe_pkg::*; #(
    parameter int DIVISOR = 16
) (
    input  wire logic                         i_clk,
    input  wire t_pipe_en                     i_en,
    input  wire logic [OPERAND_W-1:0]         i_value,
    output logic      [$clog2(DIVISOR)-1:0]   o_rem
);

    localparam int OW = $clog2(DIVISOR);
    localparam int RW = OW + 1;
    localparam logic [31:0]   RECIP   = 32'((64'd1 << 32) / DIVISOR);
    localparam logic [RW-1:0] DIV_RW  = RW'(DIVISOR);

    logic [OPERAND_W+31:0] prod;
    logic [OPERAND_W-1:0]  r_q;
    logic [OPERAND_W-1:0]  r_val;
    logic [RW+15:0]        q_wide;
    logic [RW+15:0]        val_wide;
    logic [RW-1:0]         qd;
    logic [RW-1:0]         rem;
    logic [RW-1:0]         rem_fix;
    logic [OW-1:0]         r_rem;

    assign prod = (OPERAND_W+32)'(i_value) * (OPERAND_W+32)'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en.a) begin
            r_q   <= prod[OPERAND_W+31:32];
            r_val <= i_value;
        end
    end

    // the estimate is low by at most one, so the remainder stays below twice the divisor
    assign q_wide   = (RW+16)'(r_q);
    assign val_wide = (RW+16)'(r_val);
    assign qd       = q_wide[RW-1:0] * DIV_RW;
    assign rem      = val_wide[RW-1:0] - qd;
    assign rem_fix  = (rem >= DIV_RW) ? rem - DIV_RW : rem;

    always_ff @(posedge i_clk) begin
        if (i_en.b) begin
            r_rem <= rem_fix[OW-1:0];
        end
    end

    assign o_rem = r_rem;

endmodule

`default_nettype wire

/* design/tape_machine_bytecode_executor.sv */
// Tape machine bytecode executor.
// i_in carries one instruction word: action (opcode), operand (the program
// word after the opcode) and input_byte. o_out returns one result word per
// instruction: next_pc, out_valid/out_byte for print, input_taken and halted.
// Both channels move a word when valid and ready are high at a clock edge.
// Throughput is one instruction per cycle when nothing stalls. The pipeline
// has four stages (operand reduction in two, head update with tape read,
// execute with tape write) and an output register. The tape is one memory
// with a registered read; the cell written by the executing instruction
// is forwarded to the one right behind it, so back-to-back cell updates on
// the same cell run without bubbles.
// After reset the tape is cleared one cell per cycle, all TAPE_DEPTH cells, with
// i_in.ready low; head and program counter start at zero.
// When the receiver holds o_out.ready low, the output register holds its
// word and the stages behind it keep filling until every stage is occupied,
// then i_in.ready drops.
`default_nettype none

module tape_machine_bytecode_executor import tmbe_pkg::*; #(
    parameter int TAPE_DEPTH    = 32768,
    parameter int PROGRAM_DEPTH = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tmbe_in_if.sink   i_in,
    tmbe_out_if.source o_out
);

    localparam int HW = $clog2(TAPE_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam logic [HW:0] TAPE_D  = (HW+1)'(TAPE_DEPTH);
    localparam logic [PW:0] PROG_D  = (PW+1)'(PROGRAM_DEPTH);
    localparam logic [HW-1:0] CLR_LAST = HW'(TAPE_DEPTH - 1);

    // stage enables
    logic en_out, en_d, en_c, en_b, en_a;
    logic accept;
    logic d_go;
    t_pipe_en red_en;

    // stage a
    logic                 r_a_valid;
    t_op                  r_a_action;
    logic [BYTE_W-1:0]    r_a_arg;
    logic [BYTE_W-1:0]    r_a_byte;
    // stage b
    logic                 r_b_valid;
    t_op                  r_b_action;
    logic [BYTE_W-1:0]    r_b_arg;
    logic [BYTE_W-1:0]    r_b_byte;
    logic [HW-1:0]        steps;
    logic [PW-1:0]        target;
    // stage c
    logic                 r_c_valid;
    t_op                  r_c_action;
    logic [BYTE_W-1:0]    r_c_arg;
    logic [BYTE_W-1:0]    r_c_byte;
    logic [PW-1:0]        r_c_target;
    logic [HW-1:0]        r_c_amt;
    logic                 r_c_left;
    logic [HW-1:0]        n_amt;
    logic                 n_left;
    // stage d
    logic                 r_d_valid;
    t_op                  r_d_action;
    logic [BYTE_W-1:0]    r_d_arg;
    logic [BYTE_W-1:0]    r_d_byte;
    logic [PW-1:0]        r_d_target;
    logic [HW-1:0]        r_d_addr;
    // architectural state
    logic [HW-1:0]        r_head;
    logic [HW-1:0]        n_head;
    logic [HW:0]          head_diff;
    logic [HW:0]          head_sum;
    logic [PW-1:0]        r_pc;
    logic [PW-1:0]        n_pc;
    logic [PW:0]          pc_seq;
    logic [PW:0]          pc_step;
    logic [PW+15:0]       npc_wide;
    // tape memory
    logic [BYTE_W-1:0]    r_tape [TAPE_DEPTH];
    logic [BYTE_W-1:0]    r_rdata;
    logic                 mem_we;
    logic [HW-1:0]        mem_waddr;
    logic [BYTE_W-1:0]    mem_wdata;
    logic                 r_clr_busy;
    logic [HW-1:0]        r_clr_addr;
    // forwarding of the last cell write
    logic                 r_fwd_valid;
    logic [HW-1:0]        r_fwd_addr;
    logic [BYTE_W-1:0]    r_fwd_data;
    // execute
    logic [BYTE_W-1:0]    cur_byte;
    logic                 tape_we;
    logic [BYTE_W-1:0]    tape_wdata;
    logic                 two_word;
    logic                 jump;
    logic                 ex_print;
    logic                 ex_taken;
    logic                 ex_halt;
    // output register
    logic                 r_out_valid;
    logic [PC_OUT_W-1:0]  r_out_next_pc;
    logic                 r_out_print;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_taken;
    logic                 r_out_halted;

    assign en_out = !r_out_valid || o_out.ready;
    assign d_go   = r_d_valid && en_out;
    assign en_d   = !r_d_valid || en_out;
    assign en_c   = !r_c_valid || en_d;
    assign en_b   = !r_b_valid || en_c;
    assign en_a   = !r_a_valid || en_b;

    assign i_in.ready = en_a && !r_clr_busy;
    assign accept     = i_in.valid && en_a && !r_clr_busy;

    assign red_en.a = en_a;
    assign red_en.b = en_b;

    tmbe_mod_reduce #(.DIVISOR(TAPE_DEPTH)) u_steps_mod (
        .i_clk   (i_clk),
        .i_en    (red_en),
        .i_value (i_in.operand),
        .o_rem   (steps)
    );

    tmbe_mod_reduce #(.DIVISOR(PROGRAM_DEPTH)) u_target_mod (
        .i_clk   (i_clk),
        .i_en    (red_en),
        .i_value (i_in.operand),
        .o_rem   (target)
    );

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_d_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_a)   r_a_valid   <= accept;
            if (en_b)   r_b_valid   <= r_a_valid;
            if (en_c)   r_c_valid   <= r_b_valid;
            if (en_d)   r_d_valid   <= r_c_valid;
            if (en_out) r_out_valid <= r_d_valid;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_action <= t_op'(i_in.action);
            r_a_arg    <= i_in.operand[BYTE_W-1:0];
            r_a_byte   <= i_in.input_byte;
        end
        if (en_b) begin
            r_b_action <= r_a_action;
            r_b_arg    <= r_a_arg;
            r_b_byte   <= r_a_byte;
        end
        if (en_c) begin
            r_c_action <= r_b_action;
            r_c_arg    <= r_b_arg;
            r_c_byte   <= r_b_byte;
            r_c_target <= target;
            r_c_amt    <= n_amt;
            r_c_left   <= n_left;
        end
        if (en_d) begin
            r_d_action <= r_c_action;
            r_d_arg    <= r_c_arg;
            r_d_byte   <= r_c_byte;
            r_d_target <= r_c_target;
            r_d_addr   <= r_head;
        end
    end

    // head move amount and direction
    always_comb begin
        n_amt  = '0;
        n_left = 1'b0;
        case (r_b_action)
            OP_LEFT_ONE: begin
                n_amt  = HW'(1);
                n_left = 1'b1;
            end
            OP_RIGHT_ONE: begin
                n_amt  = HW'(1);
            end
            OP_LEFT_N: begin
                n_amt  = steps;
                n_left = 1'b1;
            end
            OP_RIGHT_N: begin
                n_amt  = steps;
            end
            default: begin
                n_amt  = '0;
            end
        endcase
    end

    // head wraps around the tape in both directions
    assign head_diff = {1'b0, r_head} - {1'b0, r_c_amt};
    assign head_sum  = {1'b0, r_head} + {1'b0, r_c_amt};

    always_comb begin
        if (r_c_left) begin
            n_head = head_diff[HW] ? HW'(head_diff + TAPE_D) : head_diff[HW-1:0];
        end else begin
            n_head = (head_sum >= TAPE_D) ? HW'(head_sum - TAPE_D) : head_sum[HW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else if (r_c_valid && en_d) begin
            r_head <= n_head;
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + HW'(1);
            if (r_clr_addr == CLR_LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign mem_we    = r_clr_busy || (d_go && tape_we);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_d_addr;
    assign mem_wdata = r_clr_busy ? '0 : tape_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tape[mem_waddr] <= mem_wdata;
        end
        if (en_d) begin
            r_rdata <= r_tape[r_head];
        end
    end

    // keep the last cell write; the next instruction may have read the old value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (d_go && tape_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_go && tape_we) begin
            r_fwd_addr <= r_d_addr;
            r_fwd_data <= tape_wdata;
        end
    end

    assign cur_byte = (r_fwd_valid && r_fwd_addr == r_d_addr) ? r_fwd_data : r_rdata;

    // execute
    always_comb begin
        tape_we    = 1'b0;
        tape_wdata = cur_byte;
        two_word   = 1'b0;
        jump       = 1'b0;
        ex_print   = 1'b0;
        ex_taken   = 1'b0;
        ex_halt    = 1'b0;
        case (r_d_action)
            OP_LEFT_N, OP_RIGHT_N: begin
                two_word = 1'b1;
            end
            OP_INC: begin
                tape_we    = 1'b1;
                tape_wdata = cur_byte + 8'd1;
            end
            OP_DEC: begin
                tape_we    = 1'b1;
                tape_wdata = cur_byte - 8'd1;
            end
            OP_ADD: begin
                tape_we    = 1'b1;
                tape_wdata = cur_byte + r_d_arg;
                two_word   = 1'b1;
            end
            OP_SUB: begin
                tape_we    = 1'b1;
                tape_wdata = cur_byte - r_d_arg;
                two_word   = 1'b1;
            end
            OP_ZERO: begin
                tape_we    = 1'b1;
                tape_wdata = '0;
            end
            OP_PRINT: begin
                ex_print = 1'b1;
            end
            OP_INPUT: begin
                tape_we    = 1'b1;
                tape_wdata = r_d_byte;
                ex_taken   = 1'b1;
            end
            OP_JZ: begin
                two_word = 1'b1;
                jump     = (cur_byte == '0);
            end
            OP_JNZ: begin
                two_word = 1'b1;
                jump     = (cur_byte != '0);
            end
            OP_STOP: begin
                ex_halt = 1'b1;
            end
            default: begin
                tape_we = 1'b0;
            end
        endcase
    end

    assign pc_step = {1'b0, r_pc} + (two_word ? (PW+1)'(2) : (PW+1)'(1));
    assign pc_seq  = (pc_step >= PROG_D) ? pc_step - PROG_D : pc_step;

    always_comb begin
        if (ex_halt) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = r_d_target;
        end else begin
            n_pc = pc_seq[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else if (d_go) begin
            r_pc <= n_pc;
        end
    end

    assign npc_wide = (PW+16)'(n_pc);

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_next_pc <= npc_wide[PC_OUT_W-1:0];
            r_out_print   <= ex_print;
            r_out_byte    <= ex_print ? cur_byte : '0;
            r_out_taken   <= ex_taken;
            r_out_halted  <= ex_halt;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.next_pc     = r_out_next_pc;
    assign o_out.out_valid   = r_out_print;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.input_taken = r_out_taken;
    assign o_out.halted      = r_out_halted;

endmodule

`default_nettype wire

/* tb/tape_machine_bytecode_executor_tb.sv */
module tape_machine_bytecode_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tmbe_pkg::*;

    localparam int TAPE_DEPTH    = 32768;
    localparam int PROGRAM_DEPTH = 65536;
    localparam int HEAD_W        = $clog2(TAPE_DEPTH);
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int HOLD_CYCLES   = 400;

    // opcode 15 has no meaning and must behave as nop
    localparam logic [ACTION_W-1:0] OP_UNUSED = 4'hF;

    typedef struct packed {
        logic [PC_OUT_W-1:0] next_pc;
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
        logic                input_taken;
        logic                halted;
    } t_step_result;

    logic clk = 1'b0;
    logic rst_n;

    tmbe_in_if  instr_ch ();
    tmbe_out_if result_ch ();

    tape_machine_bytecode_executor #(
        .TAPE_DEPTH    (TAPE_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    // machine state as the testbench expects it
    logic [BYTE_W-1:0]    tape_image [TAPE_DEPTH];
    logic [HEAD_W-1:0]    head_pos;
    logic [PC_OUT_W-1:0]  prog_ctr;
    t_step_result         pending_results [$];

    int mismatches    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count;

    always #5 clk = ~clk;

    // run one instruction on the expected machine and return its result word
    function automatic t_step_result execute_word(logic [ACTION_W-1:0] act,
                                                  logic [OPERAND_W-1:0] opd,
                                                  logic [BYTE_W-1:0] byt);
        t_step_result res;
        logic [BYTE_W-1:0] cur_val;
        logic [HEAD_W-1:0] steps;
        res     = '0;
        cur_val = tape_image[head_pos];
        steps   = HEAD_W'(opd % TAPE_DEPTH);
        res.next_pc = prog_ctr + 16'd1;
        case (t_op'(act))
            OP_LEFT_ONE:  head_pos = head_pos - HEAD_W'(1);
            OP_RIGHT_ONE: head_pos = head_pos + HEAD_W'(1);
            OP_LEFT_N: begin
                head_pos    = head_pos - steps;
                res.next_pc = prog_ctr + 16'd2;
            end
            OP_RIGHT_N: begin
                head_pos    = head_pos + steps;
                res.next_pc = prog_ctr + 16'd2;
            end
            OP_INC: tape_image[head_pos] = cur_val + 8'd1;
            OP_DEC: tape_image[head_pos] = cur_val - 8'd1;
            OP_ADD: begin
                tape_image[head_pos] = cur_val + opd[7:0];
                res.next_pc          = prog_ctr + 16'd2;
            end
            OP_SUB: begin
                tape_image[head_pos] = cur_val - opd[7:0];
                res.next_pc          = prog_ctr + 16'd2;
            end
            OP_ZERO: tape_image[head_pos] = '0;
            OP_PRINT: begin
                res.out_valid = 1'b1;
                res.out_byte  = cur_val;
            end
            OP_INPUT: begin
                tape_image[head_pos] = byt;
                res.input_taken      = 1'b1;
            end
            OP_JZ:  res.next_pc = (cur_val == 8'd0) ? opd : prog_ctr + 16'd2;
            OP_JNZ: res.next_pc = (cur_val != 8'd0) ? opd : prog_ctr + 16'd2;
            OP_STOP: begin
                res.next_pc = prog_ctr;
                res.halted  = 1'b1;
            end
            default: ;
        endcase
        prog_ctr = res.next_pc;
        return res;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, want, got);
        end
    endfunction

    // offer one word, idling first at the current rate; valid stays high after
    // acceptance so back-to-back words need no second assignment in one step
    task automatic send_word(input logic [ACTION_W-1:0] act,
                             input logic [OPERAND_W-1:0] opd,
                             input logic [BYTE_W-1:0] byt);
        while ($urandom_range(99) < send_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        instr_ch.valid      <= 1'b1;
        instr_ch.action     <= act;
        instr_ch.operand    <= opd;
        instr_ch.input_byte <= byt;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        pending_results.insert(pending_results.size(), execute_word(act, opd, byt));
    endtask

    task automatic drop_valid();
        instr_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen       <= hold_req;
            hold_left       <= HOLD_CYCLES - 1;
            result_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            result_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin : result_check
        t_step_result want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual next_pc 0x%0h",
                         $time, result_ch.next_pc);
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", 32'(want.next_pc), 32'(result_ch.next_pc));
                check_field("out_valid", 32'(want.out_valid), 32'(result_ch.out_valid));
                check_field("out_byte", 32'(want.out_byte), 32'(result_ch.out_byte));
                check_field("input_taken", 32'(want.input_taken),
                            32'(result_ch.input_taken));
                check_field("halted", 32'(want.halted), 32'(result_ch.halted));
            end
        end
    end

    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    // wrap cases on head, cells and program counter, every opcode, stop and
    // the unused opcode
    task automatic test_directed_cases();
        send_word(OP_NOP,       16'h0000, 8'h00);
        send_word(OP_LEFT_ONE,  16'hFFFF, 8'hFF);   // head wraps to the top cell
        send_word(OP_PRINT,     16'h0000, 8'h00);
        send_word(OP_DEC,       16'h0000, 8'h00);   // the top cell wraps to 255
        send_word(OP_INC,       16'h0000, 8'h00);   // and back to 0
        send_word(OP_SUB,       16'hFF01, 8'h00);   // low byte only
        send_word(OP_ADD,       16'hFFFF, 8'h00);
        send_word(OP_PRINT,     16'hFFFF, 8'hFF);
        send_word(OP_RIGHT_ONE, 16'h0000, 8'h00);   // back to cell 0
        send_word(OP_INPUT,     16'h0000, 8'hFF);
        send_word(OP_PRINT,     16'h0000, 8'h00);
        send_word(OP_RIGHT_N,   16'hFFFF, 8'h00);   // count reduced mod tape depth
        send_word(OP_LEFT_N,    16'h8000, 8'h00);   // reduces to no move
        send_word(OP_PRINT,     16'h0000, 8'h00);
        send_word(OP_JNZ,       16'hFFFF, 8'h00);   // taken to the last address
        send_word(OP_JZ,        16'h1234, 8'h00);   // not taken, counter wraps by two
        send_word(OP_ZERO,      16'h0000, 8'h00);
        send_word(OP_JZ,        16'hFFFF, 8'h00);   // taken
        send_word(OP_NOP,       16'hFFFF, 8'hFF);   // counter wraps by one
        send_word(OP_JNZ,       16'hABCD, 8'h00);   // not taken
        send_word(OP_STOP,      16'h0000, 8'h00);
        send_word(OP_STOP,      16'hFFFF, 8'hFF);   // no halted state kept
        send_word(OP_UNUSED,    16'h5A5A, 8'hA5);
        send_word(OP_INPUT,     16'hFFFF, 8'h00);
        send_word(OP_PRINT,     16'h0000, 8'h00);
        wait_drained();
    endtask

    task automatic test_random_program(input int count);
        logic [ACTION_W-1:0]  act;
        logic [OPERAND_W-1:0] opd;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            opd  = OPERAND_W'($urandom_range(16'hFFFF));
            if      (pick < 8)  act = OP_LEFT_ONE;
            else if (pick < 16) act = OP_RIGHT_ONE;
            else if (pick < 22) act = OP_LEFT_N;
            else if (pick < 28) act = OP_RIGHT_N;
            else if (pick < 38) act = OP_INC;
            else if (pick < 46) act = OP_DEC;
            else if (pick < 54) act = OP_ADD;
            else if (pick < 60) act = OP_SUB;
            else if (pick < 64) act = OP_ZERO;
            else if (pick < 74) act = OP_PRINT;
            else if (pick < 80) act = OP_INPUT;
            else if (pick < 86) act = OP_JZ;
            else if (pick < 92) act = OP_JNZ;
            else if (pick < 96) act = OP_STOP;
            else if (pick < 98) act = OP_NOP;
            else                act = OP_UNUSED;
            // keep the head near a few cells so updates hit the same cells
            if ((act == OP_LEFT_N || act == OP_RIGHT_N) && $urandom_range(3) != 0)
                opd = OPERAND_W'($urandom_range(3));
            if ((act == OP_JZ || act == OP_JNZ) && $urandom_range(9) == 0)
                opd = OPERAND_W'(32'hFFFF - $urandom_range(1));
            send_word(act, opd, BYTE_W'($urandom_range(255)));
        end
    endtask

    // hold the output long enough for the pipeline to fill and stall the input
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req     <= hold_req + 1;
        test_random_program(60);
        wait_drained();
    endtask

    initial begin
        instr_ch.valid      = 1'b0;
        instr_ch.action     = '0;
        instr_ch.operand    = '0;
        instr_ch.input_byte = '0;
        result_ch.ready     = 1'b0;
        rst_n               = 1'b0;
        for (int i = 0; i < TAPE_DEPTH; i++)
            tape_image[i] = '0;
        head_pos = '0;
        prog_ctr = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 84;
        test_directed_cases();

        send_idle_pct = 13;
        recv_idle_pct = 84;
        test_random_program(160);
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 13;
        test_random_program(160);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_program(160);
        wait_drained();

        test_output_stall();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
